>>> sv/wsfd_pkg.sv
// ---------------------------------------------------------------------------
// wsfd_pkg: shared types and constants of the WebSocket frame decoder
// Field widths, header codes, parser phase encoding and the result record.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wsfd_pkg;

	// frame counter width (wraps at this width, shown on 32 bits)
	localparam int FRAME_COUNT_BITS = 32;
	localparam int FRAME_NUM_W      = 32;
	localparam int LIMIT_W          = 25;
	localparam int LEN_W            = 64;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(25'h1000000);

	// header codes
	localparam logic [3:0] OP_CLOSE   = 4'h8;
	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	// parser phases, one-hot
	typedef enum logic [4:0] {
		PH_HDR0    = 5'b00001,
		PH_HDR1    = 5'b00010,
		PH_EXTLEN  = 5'b00100,
		PH_MASKKEY = 5'b01000,
		PH_PAYLOAD = 5'b10000
	} phase_t;

	// one result transaction
	typedef struct packed {
		logic [7:0]             payload_byte;
		logic                   has_byte;
		logic [3:0]             frame_opcode;
		logic                   final_fragment;
		logic                   end_of_frame;
		logic                   status;
		logic [FRAME_NUM_W-1:0] frame_number;
	} result_t;

endpackage

`default_nettype wire

>>> sv/wsfd_byte_if.sv
// ---------------------------------------------------------------------------
// wsfd_byte_if: received byte stream channel
// Valid/ready channel carrying one stream byte per transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wsfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

>>> sv/wsfd_result_if.sv
// ---------------------------------------------------------------------------
// wsfd_result_if: decoded result channel
// Valid/ready channel carrying one unmasked byte or frame event.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wsfd_result_if
	import wsfd_pkg::*;
;
	logic                   valid;
	logic                   ready;
	logic [7:0]             payload_byte;
	logic                   has_byte;
	logic [3:0]             frame_opcode;
	logic                   final_fragment;
	logic                   end_of_frame;
	logic                   status;
	logic [FRAME_NUM_W-1:0] frame_number;

	modport source (output valid, output payload_byte, output has_byte,
		output frame_opcode, output final_fragment, output end_of_frame,
		output status, output frame_number, input ready);
	modport sink   (input valid, input payload_byte, input has_byte,
		input frame_opcode, input final_fragment, input end_of_frame,
		input status, input frame_number, output ready);
endinterface

`default_nettype wire

>>> sv/wsfd_parser.sv
// ---------------------------------------------------------------------------
// wsfd_parser: frame header parser and payload unmasker
// Updates the frame state on each accepted byte and produces at most one
// result in the same cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsfd_parser
	import wsfd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [7:0]         in_byte,
	input  wire logic [LIMIT_W-1:0] max_len,
	output logic                    res_valid,
	output result_t                 res
);

	phase_t                      phase_q, phase_d;
	logic [3:0]                  field_q, field_d;
	logic [3:0]                  opcode_q, opcode_d;
	logic                        fin_q, fin_d;
	logic                        mask_q, mask_d;
	logic [LEN_W-1:0]            len_q, len_d;
	logic [LIMIT_W-1:0]          bytes_q, bytes_d;
	logic [31:0]                 key_q, key_d;
	logic [FRAME_COUNT_BITS-1:0] frames_q, frames_d;
	logic                        stopped_q, stopped_d;

	// next state and result
	always_comb begin
		logic               len_done;
		logic               hdr_done;
		logic [LIMIT_W-1:0] bytes_inc;
		logic [7:0]         key_byte;
		logic [3:0]         field_dec;

		phase_d   = phase_q;
		field_d   = field_q;
		opcode_d  = opcode_q;
		fin_d     = fin_q;
		mask_d    = mask_q;
		len_d     = len_q;
		bytes_d   = bytes_q;
		key_d     = key_q;
		frames_d  = frames_q;
		stopped_d = stopped_q;
		len_done  = 1'b0;
		hdr_done  = 1'b0;
		bytes_inc = bytes_q + LIMIT_W'(1);
		field_dec = field_q - 4'd1;
		res_valid = 1'b0;
		res       = '0;

		case (bytes_q[1:0])
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase

		if (accept && !stopped_q) begin
			case (phase_q)
				PH_HDR0: begin
					fin_d    = in_byte[7];
					opcode_d = in_byte[3:0];
					phase_d  = PH_HDR1;
				end
				PH_HDR1: begin
					mask_d = in_byte[7];
					if (in_byte[6:0] == LEN7_EXT16 || in_byte[6:0] == LEN7_EXT64) begin
						len_d   = '0;
						field_d = (in_byte[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
						phase_d = PH_EXTLEN;
					end else begin
						len_d    = LEN_W'(in_byte[6:0]);
						len_done = 1'b1;
					end
				end
				PH_EXTLEN: begin
					len_d    = {len_q[LEN_W-9:0], in_byte};
					field_d  = field_dec;
					len_done = (field_dec == 4'd0);
				end
				PH_MASKKEY: begin
					key_d    = {key_q[23:0], in_byte};
					field_d  = field_dec;
					hdr_done = (field_dec == 4'd0);
				end
				PH_PAYLOAD: begin
					bytes_d            = bytes_inc;
					res_valid          = 1'b1;
					res.payload_byte   = in_byte ^ key_byte;
					res.has_byte       = 1'b1;
					res.frame_opcode   = opcode_q;
					res.final_fragment = fin_q;
					res.frame_number   = FRAME_NUM_W'(frames_q);
					if (LEN_W'(bytes_inc) >= len_q) begin
						res.end_of_frame = 1'b1;
						phase_d          = PH_HDR0;
						if (opcode_q == OP_CLOSE) stopped_d = 1'b1;
					end
				end
				default: phase_d = PH_HDR0;
			endcase

			// length known: mask key follows or header is complete
			if (len_done) begin
				key_d = '0;
				if (mask_d) begin
					phase_d = PH_MASKKEY;
					field_d = KEY_BYTES;
				end else begin
					hdr_done = 1'b1;
				end
			end

			// header complete: limit check, frame count, empty frame
			if (hdr_done) begin
				res.frame_opcode   = opcode_d;
				res.final_fragment = fin_d;
				res.end_of_frame   = 1'b1;
				if (len_d > LEN_W'(max_len)) begin
					res_valid        = 1'b1;
					res.status       = 1'b1;
					res.frame_number = FRAME_NUM_W'(frames_q);
					stopped_d        = 1'b1;
				end else begin
					frames_d = frames_q + FRAME_COUNT_BITS'(1);
					bytes_d  = '0;
					if (len_d == '0) begin
						res_valid        = 1'b1;
						res.frame_number = FRAME_NUM_W'(frames_d);
						phase_d          = PH_HDR0;
						if (opcode_d == OP_CLOSE) stopped_d = 1'b1;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR0;
			field_q   <= '0;
			opcode_q  <= '0;
			fin_q     <= 1'b0;
			mask_q    <= 1'b0;
			len_q     <= '0;
			bytes_q   <= '0;
			key_q     <= '0;
			frames_q  <= '0;
			stopped_q <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			field_q   <= field_d;
			opcode_q  <= opcode_d;
			fin_q     <= fin_d;
			mask_q    <= mask_d;
			len_q     <= len_d;
			bytes_q   <= bytes_d;
			key_q     <= key_d;
			frames_q  <= frames_d;
			stopped_q <= stopped_d;
		end
	end

	// halt is sticky until reset
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("parser left halt");

	// an error result halts the parser
	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status) |=> stopped_q)
		else $error("error result without halt");

	// a result without a byte always ends its frame
	a_empty_eof: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.has_byte) |-> res.end_of_frame)
		else $error("empty result not marked end of frame");

	// payload phase never holds an empty frame
	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (len_q != '0))
		else $error("payload phase with zero length");

endmodule

`default_nettype wire

>>> sv/websocket_frame_decoder_top.sv
// ---------------------------------------------------------------------------
// websocket_frame_decoder_top: byte-serial WebSocket frame decoder
//
// Usage:
//  - stream: valid/ready sink, one received byte per transaction.
//  - result: valid/ready source, one unmasked payload byte, empty-frame mark
//    or length error per transaction, tagged with opcode, FIN, end of frame
//    and frame number. Header bytes produce no transaction except the one
//    that completes an empty or over-limit frame.
//  - cfg_wr_en / cfg_wr_data: payload length limit, write while idle.
//  - Throughput: one byte per cycle while stream.ready is high. A result
//    passes combinationally through the header parser and is registered
//    in the output register, or in the skid entry while a result waits.
//  - Stall: a two-entry output buffer (output register plus skid) lets
//    the block take one more byte while a result waits; stream.ready drops
//    only while the skid entry is full.
//  - Reset: parser goes to header wait, counters clear, limit returns to
//    16777216, no result pending. After an error or a close frame ends,
//    bytes are still taken but ignored until reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_decoder_top
	import wsfd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	wsfd_byte_if.sink               stream,
	wsfd_result_if.source           result,
	input  wire logic               cfg_wr_en,
	input  wire logic [LIMIT_W-1:0] cfg_wr_data
);

	logic [LIMIT_W-1:0] limit_q;
	logic               accept;
	logic               res_valid;
	result_t            res;
	logic               out_valid_q;
	result_t            out_data_q;
	logic               skid_valid_q;
	result_t            skid_data_q;
	logic               drain;

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	assign stream.ready = !skid_valid_q;
	assign accept       = stream.valid && stream.ready;

	wsfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_byte   (stream.in_byte),
		.max_len   (limit_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// output register with skid entry
	assign drain = out_valid_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (drain) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (out_valid_q && !drain) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (drain) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (drain) out_data_q <= skid_data_q;
		end else if (res_valid) begin
			if (out_valid_q && !drain) begin
				skid_data_q <= res;
			end else begin
				out_data_q <= res;
			end
		end
	end

	assign result.valid          = out_valid_q;
	assign result.payload_byte   = out_data_q.payload_byte;
	assign result.has_byte       = out_data_q.has_byte;
	assign result.frame_opcode   = out_data_q.frame_opcode;
	assign result.final_fragment = out_data_q.final_fragment;
	assign result.end_of_frame   = out_data_q.end_of_frame;
	assign result.status         = out_data_q.status;
	assign result.frame_number   = out_data_q.frame_number;

	// skid only fills behind a full output register
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry without output entry");

	// a new result never lands while both entries are full
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !drain) |=> skid_valid_q)
		else $error("skid entry lost");

	// a stalled result with no new input stays valid
	a_hold_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |=> out_valid_q)
		else $error("pending result dropped");

endmodule

`default_nettype wire
